// ===== sv/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, codes and the record that travels from the front part to
// the back part.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CW   = 16;          // coefficient width, Q8.8
  localparam int DW   = 35;          // discriminant output width
  localparam int RW   = 32;          // root width, Q16.16
  localparam int SW   = 17;          // square root width (D < 2^34)
  localparam int SQ_STEPS = SW;      // one root bit per stage
  localparam int NUMW = 34;          // |(-b +- s) * 2^16| fits in 34 bits
  localparam int DENW = CW + 1;      // |2a|
  localparam int QW   = NUMW;        // quotient magnitude width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    CLS_TWO  = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_NONE = 2'd2
  } root_class_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic [DW-1:0]        disc;      // already clipped, two's complement
    logic [DW-2:0]        disc_mag;  // nonnegative discriminant value
    root_class_t          cls;
    logic                 degenerate;
    logic signed [CW-1:0] smallest;
  } front_item_t;

endpackage

// ===== sv/qrs_front.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver front part
// Forms the discriminant in two registered stages, classifies it and picks
// the strictly smallest coefficient, or c when no coefficient is strictly smallest.
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [qrs_pkg::CW-1:0] in_coef_a,
  input  logic signed [qrs_pkg::CW-1:0] in_coef_b,
  input  logic signed [qrs_pkg::CW-1:0] in_coef_c,
  output logic                        fr_valid,
  output qrs_pkg::front_item_t        fr_item
);

  // Stage one: products.
  logic                          v1_r;
  logic signed [qrs_pkg::CW-1:0] a1_r, b1_r, c1_r;
  logic [2*qrs_pkg::CW-1:0]      q1_r;
  logic signed [2*qrs_pkg::CW-1:0] p1_r;
  logic [qrs_pkg::CW-1:0]        bmag;

  assign bmag = in_coef_b[qrs_pkg::CW-1] ? (~in_coef_b + 1'b1) : in_coef_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    a1_r <= in_coef_a;
    b1_r <= in_coef_b;
    c1_r <= in_coef_c;
    q1_r <= bmag * bmag;
    p1_r <= in_coef_a * in_coef_c;
  end

  // Stage two: difference, clipping, class and smallest coefficient.
  logic signed [2*qrs_pkg::CW+3:0] d_full;
  logic [qrs_pkg::DW-1:0]          d_clip;
  logic                            neg, zero;
  logic signed [qrs_pkg::CW-1:0]   min_coef;
  qrs_pkg::front_item_t            item;

  assign d_full = $signed({4'b0, q1_r}) - ($signed({{2{p1_r[2*qrs_pkg::CW-1]}}, p1_r}) <<< 2);
  assign neg  = d_full < 0;
  assign zero = d_full == 0;

  always_comb begin
    if (d_full > $signed({{(2*qrs_pkg::CW+4-qrs_pkg::DW+1){1'b0}}, {(qrs_pkg::DW-1){1'b1}}}))
      d_clip = {1'b0, {(qrs_pkg::DW-1){1'b1}}};
    else if (d_full < -$signed({{(2*qrs_pkg::CW+4-qrs_pkg::DW){1'b0}}, 1'b1, {(qrs_pkg::DW-1){1'b0}}}))
      d_clip = {1'b1, {(qrs_pkg::DW-1){1'b0}}};
    else
      d_clip = d_full[qrs_pkg::DW-1:0];
    if (a1_r < b1_r && a1_r < c1_r) min_coef = a1_r;
    else if (b1_r < a1_r && b1_r < c1_r) min_coef = b1_r;
    else min_coef = c1_r;
    item.coef_a     = a1_r;
    item.coef_b     = b1_r;
    item.disc       = d_clip;
    item.disc_mag   = neg ? '0 : d_full[qrs_pkg::DW-2:0];
    item.cls        = neg ? qrs_pkg::CLS_NONE : (zero ? qrs_pkg::CLS_ONE : qrs_pkg::CLS_TWO);
    item.degenerate = a1_r == '0;
    item.smallest   = min_coef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= v1_r;
    end
    fr_item <= item;
  end

endmodule

// ===== sv/qrs_fifo.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module qrs_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  qrs_pkg::front_item_t wr_item,
  input  logic                 rd_en,
  output logic                 rd_valid,
  output qrs_pkg::front_item_t rd_item,
  output logic                 full
);

  qrs_pkg::front_item_t            mem_r [qrs_pkg::FIFO_DEPTH];
  logic [qrs_pkg::FIFO_AW-1:0]     wp_r, rp_r;
  logic [qrs_pkg::FIFO_AW:0]       cnt_r, cnt_nxt;

  assign rd_valid = cnt_r != '0;
  assign full     = cnt_r == (qrs_pkg::FIFO_AW+1)'(qrs_pkg::FIFO_DEPTH);
  assign rd_item  = mem_r[rp_r];
  assign cnt_nxt  = cnt_r + (qrs_pkg::FIFO_AW+1)'(wr_en) - (qrs_pkg::FIFO_AW+1)'(rd_en && rd_valid);

  // Storage is written in place; pointers and count reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en && rd_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en || rd_en) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r != '0) else $error("queue count lost an item");
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !(rd_en && rd_valid)) else $error("read from empty queue");
`endif

endmodule

// ===== sv/qrs_back.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver back part
// Pipelined square root (one root bit per stage), then a pipelined
// restoring divide (one quotient bit per stage), then saturation.
// ----------------------------------------------------------------------------
module qrs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  qrs_pkg::front_item_t          in_item,
  output logic                          out_strobe,
  output logic signed [qrs_pkg::DW-1:0] out_discriminant,
  output logic [1:0]                    out_root_class,
  output logic signed [qrs_pkg::RW-1:0] out_root_plus,
  output logic signed [qrs_pkg::RW-1:0] out_root_minus,
  output logic                          out_degenerate,
  output logic                          out_saturated,
  output logic signed [qrs_pkg::CW-1:0] out_smallest_coef
);

  localparam int SQS = qrs_pkg::SQ_STEPS;
  localparam int DVS = qrs_pkg::QW;
  localparam int RMW = qrs_pkg::SW + 2;

  // ---------------- Square root pipeline ----------------
  logic                   sv_r   [SQS+1];
  qrs_pkg::front_item_t   sit_r  [SQS+1];
  logic [2*SQS-1:0]       srad_r [SQS+1];
  logic [RMW-1:0]         srem_r [SQS+1];
  logic [SQS-1:0]         sroot_r[SQS+1];

  always_comb begin
    sv_r[0]    = in_valid;
    sit_r[0]   = in_item;
    srad_r[0]  = (2*SQS)'(in_item.disc_mag);
    srem_r[0]  = '0;
    sroot_r[0] = '0;
  end

  for (genvar k = 0; k < SQS; k++) begin : g_sq
    logic [RMW-1:0] rem_sh, trial;
    assign rem_sh = {srem_r[k][RMW-3:0], srad_r[k][2*SQS-1 -: 2]};
    assign trial  = {sroot_r[k][RMW-3:0], 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
      sit_r[k+1]  <= sit_r[k];
      srad_r[k+1] <= srad_r[k] << 2;
      if (rem_sh >= trial) begin
        srem_r[k+1]  <= rem_sh - trial;
        sroot_r[k+1] <= {sroot_r[k][SQS-2:0], 1'b1};
      end else begin
        srem_r[k+1]  <= rem_sh;
        sroot_r[k+1] <= {sroot_r[k][SQS-2:0], 1'b0};
      end
    end
  end

  // ---------------- Numerator setup ----------------
  logic                             nv_r;
  qrs_pkg::front_item_t             nit_r;
  logic [qrs_pkg::NUMW-1:0]         np_r, nm_r;
  logic                             nps_r, nms_r;
  logic [qrs_pkg::DENW-1:0]         den_r;
  logic signed [qrs_pkg::CW+1:0]    sp, sm;

  assign sp = -$signed({{2{sit_r[SQS].coef_b[qrs_pkg::CW-1]}}, sit_r[SQS].coef_b})
              + $signed({1'b0, sroot_r[SQS]});
  assign sm = -$signed({{2{sit_r[SQS].coef_b[qrs_pkg::CW-1]}}, sit_r[SQS].coef_b})
              - $signed({1'b0, sroot_r[SQS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else begin
      nv_r <= sv_r[SQS];
    end
    nit_r <= sit_r[SQS];
    // Quotient sign is the numerator sign xor the sign of a.
    nps_r <= sp[qrs_pkg::CW+1] ^ sit_r[SQS].coef_a[qrs_pkg::CW-1];
    nms_r <= sm[qrs_pkg::CW+1] ^ sit_r[SQS].coef_a[qrs_pkg::CW-1];
    // The numerator magnitude can need more than CW bits.
    np_r  <= {(sp[qrs_pkg::CW+1] ? (qrs_pkg::CW+2)'(-sp) : (qrs_pkg::CW+2)'(sp)), 16'b0};
    nm_r  <= {(sm[qrs_pkg::CW+1] ? (qrs_pkg::CW+2)'(-sm) : (qrs_pkg::CW+2)'(sm)), 16'b0};
    den_r <= sit_r[SQS].coef_a[qrs_pkg::CW-1]
             ? qrs_pkg::DENW'(-{sit_r[SQS].coef_a, 1'b0})
             : qrs_pkg::DENW'({sit_r[SQS].coef_a, 1'b0});
  end

  // ---------------- Divider pipeline, both roots side by side ----------------
  localparam int RDW = qrs_pkg::DENW + 1;
  logic                       dv_r  [DVS+1];
  qrs_pkg::front_item_t       dit_r [DVS+1];
  logic [qrs_pkg::DENW-1:0]   dden_r[DVS+1];
  logic                       dps_r [DVS+1];
  logic                       dms_r [DVS+1];
  logic [qrs_pkg::NUMW-1:0]   pq_r  [DVS+1];
  logic [qrs_pkg::NUMW-1:0]   mq_r  [DVS+1];
  logic [RDW-1:0]             pr_r  [DVS+1];
  logic [RDW-1:0]             mr_r  [DVS+1];

  always_comb begin
    dv_r[0]   = nv_r;
    dit_r[0]  = nit_r;
    dden_r[0] = den_r;
    dps_r[0]  = nps_r;
    dms_r[0]  = nms_r;
    pq_r[0]   = np_r;
    mq_r[0]   = nm_r;
    pr_r[0]   = '0;
    mr_r[0]   = '0;
  end

  // The quotient register shifts the numerator out as quotient bits shift in.
  for (genvar k = 0; k < DVS; k++) begin : g_dv
    logic [RDW-1:0] ptry, mtry;
    assign ptry = {pr_r[k][RDW-2:0], pq_r[k][qrs_pkg::NUMW-1]};
    assign mtry = {mr_r[k][RDW-2:0], mq_r[k][qrs_pkg::NUMW-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      dit_r[k+1]  <= dit_r[k];
      dden_r[k+1] <= dden_r[k];
      dps_r[k+1]  <= dps_r[k];
      dms_r[k+1]  <= dms_r[k];
      if (ptry >= {1'b0, dden_r[k]}) begin
        pr_r[k+1] <= ptry - {1'b0, dden_r[k]};
        pq_r[k+1] <= {pq_r[k][qrs_pkg::NUMW-2:0], 1'b1};
      end else begin
        pr_r[k+1] <= ptry;
        pq_r[k+1] <= {pq_r[k][qrs_pkg::NUMW-2:0], 1'b0};
      end
      if (mtry >= {1'b0, dden_r[k]}) begin
        mr_r[k+1] <= mtry - {1'b0, dden_r[k]};
        mq_r[k+1] <= {mq_r[k][qrs_pkg::NUMW-2:0], 1'b1};
      end else begin
        mr_r[k+1] <= mtry;
        mq_r[k+1] <= {mq_r[k][qrs_pkg::NUMW-2:0], 1'b0};
      end
    end
  end

  // ---------------- Sign, saturation and output register ----------------
  logic                          rp_clip, rm_clip, live;
  logic signed [qrs_pkg::RW-1:0] rp_val, rm_val;
  qrs_pkg::front_item_t          fit;

  assign fit  = dit_r[DVS];
  assign live = !fit.degenerate && fit.cls != qrs_pkg::CLS_NONE;

  function automatic logic [qrs_pkg::RW:0] sat_root(input logic [qrs_pkg::NUMW-1:0] mag,
                                                     input logic neg);
    logic [qrs_pkg::RW:0] res;
    res = '0;
    if (neg) begin
      if (mag > qrs_pkg::NUMW'(34'h080000000))
        res = {1'b1, 1'b1, {(qrs_pkg::RW-1){1'b0}}};
      else
        res = {1'b0, qrs_pkg::RW'(-mag)};
    end else begin
      if (mag > qrs_pkg::NUMW'(34'h07FFFFFFF))
        res = {1'b1, 1'b0, {(qrs_pkg::RW-1){1'b1}}};
      else
        res = {1'b0, mag[qrs_pkg::RW-1:0]};
    end
    return res;
  endfunction

  assign {rp_clip, rp_val} = sat_root(pq_r[DVS], dps_r[DVS]);
  assign {rm_clip, rm_val} = sat_root(mq_r[DVS], dms_r[DVS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= dv_r[DVS];
    end
    out_discriminant  <= fit.disc;
    out_root_class    <= fit.cls;
    out_root_plus     <= live ? rp_val : '0;
    out_root_minus    <= live ? rm_val : '0;
    out_degenerate    <= fit.degenerate;
    out_saturated     <= live && (rp_clip || rm_clip);
    out_smallest_coef <= fit.smallest;
  end

`ifndef SYNTH
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_root_class == qrs_pkg::CLS_NONE |->
      out_root_plus == '0 && out_root_minus == '0 && !out_saturated)
    else $error("no-root item has nonzero roots");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_degenerate |-> out_root_plus == '0 && !out_saturated)
    else $error("degenerate item has roots");
  a_repeated: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_root_class == qrs_pkg::CLS_ONE |-> out_root_plus == out_root_minus)
    else $error("repeated root differs");
`endif

endmodule

// ===== sv/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_coef_a/b/c (signed Q8.8) and pulse start; the item is taken at
//   a rising edge where start is high and busy is low. busy stays low in
//   normal use, so one item may be taken every cycle.
//   Each result appears for one cycle with out_strobe high, in input order:
//   discriminant (Q19.16), root class, both roots (Q16.16, saturated),
//   degenerate and saturated flags, and the smallest coefficient.
//   The path runs through 2 front stages, the queue register, 17 square root
//   stages, 1 numerator stage, 34 divide stages and the output register.
//   Throughput is one item per cycle, set by the one-bit-per-stage square
//   root and divide pipelines.
//   The receiver cannot stall and the back part never holds, so the queue
//   holds at most one item and busy stays low.
//   Synchronous reset (rst_n low) empties every stage and the queue.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [qrs_pkg::CW-1:0] in_coef_a,
  input  logic signed [qrs_pkg::CW-1:0] in_coef_b,
  input  logic signed [qrs_pkg::CW-1:0] in_coef_c,
  output logic                          out_strobe,
  output logic signed [qrs_pkg::DW-1:0] out_discriminant,
  output logic [1:0]                    out_root_class,
  output logic signed [qrs_pkg::RW-1:0] out_root_plus,
  output logic signed [qrs_pkg::RW-1:0] out_root_minus,
  output logic                          out_degenerate,
  output logic                          out_saturated,
  output logic signed [qrs_pkg::CW-1:0] out_smallest_coef
);

  logic                 fr_valid, q_valid, q_full, accept;
  qrs_pkg::front_item_t fr_item, q_item;

  // Items in the front pipeline could still land in the queue.
  assign busy   = q_full;
  assign accept = start && !busy;

  qrs_front u_front (
    .clk, .rst_n,
    .in_valid (accept),
    .in_coef_a, .in_coef_b, .in_coef_c,
    .fr_valid, .fr_item
  );

  qrs_fifo u_fifo (
    .clk, .rst_n,
    .wr_en    (fr_valid),
    .wr_item  (fr_item),
    .rd_en    (1'b1),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .full     (q_full)
  );

  qrs_back u_back (
    .clk, .rst_n,
    .in_valid (q_valid),
    .in_item  (q_item),
    .out_strobe, .out_discriminant, .out_root_class,
    .out_root_plus, .out_root_minus, .out_degenerate,
    .out_saturated, .out_smallest_coef
  );

endmodule

// ===== verif/quadratic_root_solver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Sends directed and random coefficient sets into the solver with random
// gaps. Every result is checked field by field against a typed-in answer
// or a predictor that works out the discriminant, the root class, both roots and the flags.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;

  localparam int RAND_ITEMS = 500;
  localparam int WATCHDOG   = 5000;
  localparam int LATENCY    = 56;

  typedef struct {
    logic signed [qrs_pkg::DW-1:0] disc;
    logic [1:0]                    cls;
    logic signed [qrs_pkg::RW-1:0] rplus;
    logic signed [qrs_pkg::RW-1:0] rminus;
    logic                          degen;
    logic                          sat;
    logic signed [qrs_pkg::CW-1:0] min_coef;
  } solution_t;

  // One directed row: coefficients, plus a typed-in answer where known.
  typedef struct {
    logic signed [qrs_pkg::CW-1:0] a, b, c;
    bit                            typed;
    solution_t                     ans;
  } coef_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [qrs_pkg::CW-1:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_strobe;
  logic signed [qrs_pkg::DW-1:0] out_discriminant;
  logic [1:0] out_root_class;
  logic signed [qrs_pkg::RW-1:0] out_root_plus, out_root_minus;
  logic out_degenerate, out_saturated;
  logic signed [qrs_pkg::CW-1:0] out_smallest_coef;

  solution_t pending_solutions[$];
  bit        failed = 1'b0;
  int        idle_cycles = 0;

  quadratic_root_solver DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, truncated, one bit pair at a time.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, rem, trial;
    root = 0;
    rem = 0;
    for (int k = 62; k >= 0; k -= 2) begin
      rem = (rem << 2) | ((v >> k) & 2'b11);
      trial = (root << 2) | 1;
      root <<= 1;
      if (rem >= trial) begin
        rem -= trial;
        root |= 1;
      end
    end
    return root;
  endfunction

  // Clip a quotient to the root range and note the clipping.
  function automatic longint clip_root(longint v, ref bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic solution_t solve_quadratic(logic signed [qrs_pkg::CW-1:0] ca,
                                                logic signed [qrs_pkg::CW-1:0] cb,
                                                logic signed [qrs_pkg::CW-1:0] cc);
    solution_t r;
    longint a, b, c, d, s, rp, rm;
    bit clipped;
    a = ca;
    b = cb;
    c = cc;
    d = b * b - 4 * a * c;
    clipped = 1'b0;
    rp = 0;
    rm = 0;
    r.disc = d[qrs_pkg::DW-1:0];
    r.cls = (d < 0) ? qrs_pkg::CLS_NONE : ((d == 0) ? qrs_pkg::CLS_ONE : qrs_pkg::CLS_TWO);
    if (d >= 0 && a != 0) begin
      s = int_sqrt(d);
      // SystemVerilog integer division truncates toward zero.
      rp = clip_root(((-b + s) * 65536) / (2 * a), clipped);
      rm = clip_root(((-b - s) * 65536) / (2 * a), clipped);
    end
    r.rplus = rp[qrs_pkg::RW-1:0];
    r.rminus = rm[qrs_pkg::RW-1:0];
    r.degen = (a == 0);
    r.sat = clipped;
    if (a < b && a < c) r.min_coef = ca;
    else if (b < a && b < c) r.min_coef = cb;
    else r.min_coef = cc;
    return r;
  endfunction

  // Random gap length: mostly none or short, sometimes long.
  function automatic int gap_len();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    return n;
  endfunction

  // Hand one item to the solver and hold start until it is taken.
  task automatic send_coefs(logic signed [qrs_pkg::CW-1:0] a,
                            logic signed [qrs_pkg::CW-1:0] b,
                            logic signed [qrs_pkg::CW-1:0] c, solution_t ans);
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (busy);
    pending_solutions.push_back(ans);
  endtask

  // Back-to-back items keep start high; start drops only over a real gap.
  task automatic send_item(logic signed [qrs_pkg::CW-1:0] a,
                           logic signed [qrs_pkg::CW-1:0] b,
                           logic signed [qrs_pkg::CW-1:0] c, solution_t ans);
    int n;
    send_coefs(a, b, c, ans);
    n = $urandom_range(0, 1) ? gap_len() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random coefficient: extremes, small values, or the full range.
  function automatic logic signed [qrs_pkg::CW-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3, 4: return qrs_pkg::CW'($urandom_range(0, 1023) - 512);
      default: return qrs_pkg::CW'($urandom());
    endcase
  endfunction

  // Result checker and watchdog.
  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_strobe) begin
      if (pending_solutions.size() == 0) begin
        $display("%0t: unexpected result disc=%0d", $time, out_discriminant);
        failed = 1'b1;
      end else begin
        e = pending_solutions.pop_front();
        if (out_discriminant !== e.disc) begin
          $display("%0t: discriminant exp %0d got %0d", $time, e.disc,
                   out_discriminant);
          failed = 1'b1;
        end
        if (out_root_class !== e.cls) begin
          $display("%0t: root_class exp %0d got %0d", $time, e.cls, out_root_class);
          failed = 1'b1;
        end
        if (out_root_plus !== e.rplus) begin
          $display("%0t: root_plus exp %0d got %0d", $time, e.rplus, out_root_plus);
          failed = 1'b1;
        end
        if (out_root_minus !== e.rminus) begin
          $display("%0t: root_minus exp %0d got %0d", $time, e.rminus,
                   out_root_minus);
          failed = 1'b1;
        end
        if (out_degenerate !== e.degen) begin
          $display("%0t: degenerate exp %0d got %0d", $time, e.degen,
                   out_degenerate);
          failed = 1'b1;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated exp %0d got %0d", $time, e.sat, out_saturated);
          failed = 1'b1;
        end
        if (out_smallest_coef !== e.min_coef) begin
          $display("%0t: smallest_coef exp %0d got %0d", $time, e.min_coef,
                   out_smallest_coef);
          failed = 1'b1;
        end
      end
    end
    if (out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  coef_row_t directed[$];

  function automatic coef_row_t row(int a, int b, int c);
    coef_row_t r;
    r.a = qrs_pkg::CW'(a);
    r.b = qrs_pkg::CW'(b);
    r.c = qrs_pkg::CW'(c);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic coef_row_t typed_row(int a, int b, int c, longint d,
                                          int cls, int rp, int rm, bit dg,
                                          bit st, int sm);
    coef_row_t r;
    r = row(a, b, c);
    r.typed = 1'b1;
    r.ans.disc = qrs_pkg::DW'(d);
    r.ans.cls = 2'(cls);
    r.ans.rplus = rp;
    r.ans.rminus = rm;
    r.ans.degen = dg;
    r.ans.sat = st;
    r.ans.min_coef = qrs_pkg::CW'(sm);
    return r;
  endfunction

  initial begin
    solution_t ans;
    // All zero: degenerate, repeated class, ties go to c.
    directed.push_back(typed_row(0, 0, 0, 0, qrs_pkg::CLS_ONE, 0, 0, 1, 0, 0));
    // x^2 - 1: roots +1 and -1 in Q16.16.
    directed.push_back(typed_row(256, 0, -256, 64'sd262144, qrs_pkg::CLS_TWO,
                                 65536, -65536, 0, 0, -256));
    // x^2 + 1: no real roots.
    directed.push_back(typed_row(256, 0, 256, -64'sd262144, qrs_pkg::CLS_NONE,
                                 0, 0, 0, 0, 0));
    // (x-1)^2: repeated root at one.
    directed.push_back(typed_row(256, -512, 256, 0, qrs_pkg::CLS_ONE,
                                 65536, 65536, 0, 0, -512));
    // Degenerate with a real discriminant.
    directed.push_back(typed_row(0, 256, 256, 64'sd65536, qrs_pkg::CLS_TWO,
                                 0, 0, 1, 0, 0));
    // Extremes and saturation cases go through the predictor.
    directed.push_back(row(-32768, -32768, -32768));
    directed.push_back(row(32767, 32767, 32767));
    directed.push_back(row(-32768, 32767, 32767));
    directed.push_back(row(32767, -32768, -32768));
    directed.push_back(row(1, -32768, 0));
    directed.push_back(row(1, 32767, -32768));
    directed.push_back(row(-1, -32768, 32767));
    directed.push_back(row(1, 0, -32768));
    directed.push_back(row(-32768, 0, 32767));
    directed.push_back(row(-32768, 0, -32768));
    directed.push_back(row(5, 5, 7));
    directed.push_back(row(7, 5, 5));
    directed.push_back(row(5, 7, 5));
    directed.push_back(row(-3, 100, 2));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      ans = directed[i].typed ? directed[i].ans
          : solve_quadratic(directed[i].a, directed[i].b, directed[i].c);
      send_item(directed[i].a, directed[i].b, directed[i].c, ans);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      logic signed [qrs_pkg::CW-1:0] a, b, c;
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
      send_item(a, b, c, solve_quadratic(a, b, c));
    end
    start <= 1'b0;

    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qrs_pkg.sv
sv/qrs_front.sv
sv/qrs_fifo.sv
sv/qrs_back.sv
sv/quadratic_root_solver.sv
verif/quadratic_root_solver_tb.sv
